// ----- rtl/depth_row_edge_trim_macros.svh -----
// Assertion macros for the depth row edge trim checker.
// Depends on nothing; each macro expects clk and rst in the including scope.
`ifndef DEPTH_ROW_EDGE_TRIM_MACROS_SVH
`define DEPTH_ROW_EDGE_TRIM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRT_ASSERT_SAME(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRT_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ----- rtl/drtrim_pkg.sv -----
// Shared widths, register indexes and controller/datapath interface types
// for the depth row edge trim block. Depends on nothing.
package drtrim_pkg;

  localparam int DEPTH_W     = 16;
  localparam int THR_W       = 16;
  localparam int CHECK_W     = 11;
  localparam int POS_W       = 10;
  localparam int LEN_W       = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int REG_INDEX_W = 1;

  localparam logic [REG_INDEX_W-1:0] REG_SLOPE_THRESHOLD = 1'd0;
  localparam logic [REG_INDEX_W-1:0] REG_CHECK_WIDTH     = 1'd1;

  localparam logic [THR_W-1:0]   THRESHOLD_RESET   = 16'd48;
  localparam logic [CHECK_W-1:0] CHECK_WIDTH_RESET = 11'd10;

  typedef struct packed {
    logic load;
    logic eval;
    logic fall_setup;
    logic finish;
    logic found;
  } drtrim_cmd_t;

  typedef struct packed {
    logic qualify;
    logic scan_done;
  } drtrim_status_t;

endpackage

// ----- rtl/drtrim_ctrl.sv -----
// Sequencer for the depth row edge trim block: accepts pixels, then steps
// through evaluation and the two refinement scans. Depends on drtrim_pkg.
module drtrim_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     row_end,
  input  drtrim_pkg::drtrim_status_t status,
  output drtrim_pkg::drtrim_cmd_t    cmd,
  output logic                     busy,
  output logic                     done
);
  import drtrim_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_RISE,
    S_FALL
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        cmd.finish = !status.qualify;
      end
      S_RISE: begin
        cmd.fall_setup = status.scan_done;
      end
      S_FALL: begin
        cmd.finish = status.scan_done;
        cmd.found  = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && row_end) begin
            state <= S_EVAL;
            busy  <= 1'b1;
          end
        end
        S_EVAL: begin
          if (status.qualify) begin
            state <= S_RISE;
          end else begin
            state <= S_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        S_RISE: begin
          if (status.scan_done) begin
            state <= S_FALL;
          end
        end
        S_FALL: begin
          if (status.scan_done) begin
            state <= S_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/drtrim_datapath.sv -----
// Datapath of the depth row edge trim block: row memory, running slope test,
// configuration registers, refinement scan unit and result registers.
// Depends on drtrim_pkg.
module drtrim_datapath #(
  parameter int ROW_MAX    = 1024,
  parameter int SLOPE_SPAN = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [drtrim_pkg::REG_INDEX_W-1:0]   cfg_index,
  input  logic [drtrim_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [drtrim_pkg::DEPTH_W-1:0]       depth,
  input  drtrim_pkg::drtrim_cmd_t              cmd,
  output drtrim_pkg::drtrim_status_t           status,
  output logic                                 edges_found,
  output logic [drtrim_pkg::POS_W-1:0]         keep_start,
  output logic [drtrim_pkg::POS_W-1:0]         keep_end,
  output logic [drtrim_pkg::LEN_W-1:0]         row_length,
  output logic                                 overflowed
);
  import drtrim_pkg::*;

  localparam int IW     = $clog2(ROW_MAX);
  localparam int CNT_W  = $clog2(ROW_MAX + 1);
  localparam int HIST_N = 2 * SLOPE_SPAN;
  localparam int LIM_W  = THR_W + $clog2(SLOPE_SPAN + 1);
  localparam int CMP_W  = LIM_W + 2;
  localparam int DIFF_W = DEPTH_W + 1;
  localparam int SUM_W  = ((CNT_W > CHECK_W) ? CNT_W : CHECK_W) + 1;

  logic [THR_W-1:0]   slope_threshold;
  logic [CHECK_W-1:0] check_width;

  logic [DEPTH_W-1:0] row_store [ROW_MAX];
  logic [DEPTH_W-1:0] hist [HIST_N];

  logic [CNT_W-1:0] pixel_count;
  logic [IW-1:0]    rising_index;
  logic             rising_seen;
  logic [IW-1:0]    falling_index;
  logic             falling_seen;
  logic             overflow_flag;

  logic [IW-1:0]      scan_addr;
  logic [IW-1:0]      scan_stop;
  logic               scan_down;
  logic               issuing;
  logic               rd_vld;
  logic [IW-1:0]      rd_pos;
  logic [DEPTH_W-1:0] rd_data;
  logic               first;
  logic [DEPTH_W-1:0] best;
  logic [IW-1:0]      best_pos;
  logic [IW-1:0]      start_pos;
  logic [IW-1:0]      fall_lo;

  logic                    room;
  logic [LIM_W-1:0]        lim;
  logic signed [DIFF_W-1:0] diff;
  logic signed [CMP_W-1:0] diff_ext;
  logic signed [CMP_W-1:0] lim_pos;
  logic signed [CMP_W-1:0] lim_neg;
  logic                    rise_hit;
  logic                    fall_hit;
  logic                    zero_rise;
  logic                    rise_seen_eff;
  logic [IW-1:0]           rise_idx_eff;
  logic [SUM_W-1:0]        rise_sum;
  logic [SUM_W-1:0]        rise_hi;
  logic [IW-1:0]           rise_stop;
  logic [IW-1:0]           fall_lo_calc;

  assign room     = pixel_count < CNT_W'(ROW_MAX);
  assign lim      = LIM_W'(slope_threshold) * LIM_W'(SLOPE_SPAN);
  assign diff     = $signed({1'b0, depth}) - $signed({1'b0, hist[HIST_N-1]});
  assign diff_ext = {{(CMP_W - DIFF_W){diff[DIFF_W-1]}}, diff};
  assign lim_pos  = $signed({2'b00, lim});
  assign lim_neg  = -lim_pos;
  assign rise_hit = diff_ext >= lim_pos;
  assign fall_hit = diff_ext <= lim_neg;

  // With a zero threshold every zero slope counts as rising, so pixel 0 wins.
  assign zero_rise     = (lim == '0) && (pixel_count >= CNT_W'(2));
  assign rise_seen_eff = rising_seen || zero_rise;
  assign rise_idx_eff  = zero_rise ? '0 : rising_index;

  assign rise_sum  = SUM_W'(rise_idx_eff) + SUM_W'(check_width);
  assign rise_hi   = (rise_sum > SUM_W'(pixel_count)) ? SUM_W'(pixel_count) : rise_sum;
  assign rise_stop = (check_width == '0) ? rise_idx_eff : IW'(rise_hi - SUM_W'(1));
  assign fall_lo_calc = (SUM_W'(falling_index) >= SUM_W'(check_width)) ?
                        IW'(SUM_W'(falling_index) - SUM_W'(check_width)) : '0;

  assign status.qualify   = rise_seen_eff && falling_seen && (rise_idx_eff < falling_index);
  assign status.scan_done = !issuing && !rd_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_threshold <= THRESHOLD_RESET;
      check_width     <= CHECK_WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOPE_THRESHOLD: slope_threshold <= cfg_data[THR_W-1:0];
        REG_CHECK_WIDTH:     check_width     <= cfg_data[CHECK_W-1:0];
        default:             slope_threshold <= slope_threshold;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count   <= '0;
      rising_index  <= '0;
      rising_seen   <= 1'b0;
      falling_index <= '0;
      falling_seen  <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (cmd.finish) begin
      pixel_count   <= '0;
      rising_index  <= '0;
      rising_seen   <= 1'b0;
      falling_index <= '0;
      falling_seen  <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (cmd.load) begin
      if (room) begin
        pixel_count <= pixel_count + CNT_W'(1);
        if (pixel_count >= CNT_W'(HIST_N)) begin
          if (rise_hit) begin
            if (!rising_seen) begin
              rising_index <= IW'(pixel_count - CNT_W'(SLOPE_SPAN));
              rising_seen  <= 1'b1;
            end
          end else if (fall_hit) begin
            falling_index <= IW'(pixel_count - CNT_W'(SLOPE_SPAN));
            falling_seen  <= 1'b1;
          end
        end
      end else begin
        overflow_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      hist[0] <= depth;
      for (int k = 1; k < HIST_N; k++) begin
        hist[k] <= hist[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      row_store[pixel_count[IW-1:0]] <= depth;
    end
    if (issuing) begin
      rd_data <= row_store[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= issuing;
      rd_pos <= scan_addr;
      if (rd_vld) begin
        first <= 1'b0;
        if (first || (rd_data > best)) begin
          best     <= rd_data;
          best_pos <= rd_pos;
        end
      end
      if (cmd.eval) begin
        scan_addr <= rise_idx_eff;
        scan_stop <= rise_stop;
        scan_down <= 1'b0;
        issuing   <= status.qualify;
        first     <= 1'b1;
        fall_lo   <= fall_lo_calc;
      end else if (cmd.fall_setup) begin
        start_pos <= best_pos;
        scan_addr <= falling_index;
        scan_stop <= fall_lo;
        scan_down <= 1'b1;
        issuing   <= 1'b1;
        first     <= 1'b1;
      end else if (issuing) begin
        if (scan_addr == scan_stop) begin
          issuing <= 1'b0;
        end else if (scan_down) begin
          scan_addr <= scan_addr - IW'(1);
        end else begin
          scan_addr <= scan_addr + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      edges_found <= cmd.found;
      keep_start  <= cmd.found ? POS_W'(start_pos) : '0;
      keep_end    <= cmd.found ? POS_W'(best_pos) : POS_W'(pixel_count - CNT_W'(1));
      row_length  <= LEN_W'(pixel_count);
      overflowed  <= overflow_flag;
    end
  end

endmodule

// ----- rtl/depth_row_edge_trim.sv -----
// Top level of the depth row edge trim block: joins the sequencer and the
// datapath. Depends on drtrim_pkg, drtrim_ctrl and drtrim_datapath.
//
//   channel  | handshake       | payload
//   ---------+-----------------+-------------------------------------------
//   pixel    | start / busy    | depth, row_end
//   result   | done (strobe)   | edges_found, keep_start, keep_end,
//            |                 | row_length, overflowed
//   config   | cfg_we          | cfg_index, cfg_data
//
// A pixel that does not end its row is taken while busy stays low.
// A row_end request holds busy through evaluation alone when the row does not
// qualify, otherwise also through the two refinement scans, which make
// R = min(check_width, length - rising) (at least 1) and F = min(check_width,
// falling) + 1 single-port reads of the row memory.
// The result is strobed on done for one cycle as busy drops; the next request
// may be taken in that same cycle. The receiver cannot stall.
// Synchronous reset restores the register defaults; the row memory needs none.
module depth_row_edge_trim #(
  parameter int ROW_MAX    = 1024,
  parameter int SLOPE_SPAN = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [drtrim_pkg::DEPTH_W-1:0]     depth,
  input  logic                               row_end,
  output logic                               done,
  output logic                               edges_found,
  output logic [drtrim_pkg::POS_W-1:0]       keep_start,
  output logic [drtrim_pkg::POS_W-1:0]       keep_end,
  output logic [drtrim_pkg::LEN_W-1:0]       row_length,
  output logic                               overflowed,
  input  logic                               cfg_we,
  input  logic [drtrim_pkg::REG_INDEX_W-1:0] cfg_index,
  input  logic [drtrim_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import drtrim_pkg::*;

  drtrim_cmd_t    cmd;
  drtrim_status_t status;

  drtrim_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .row_end (row_end),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  drtrim_datapath #(
    .ROW_MAX    (ROW_MAX),
    .SLOPE_SPAN (SLOPE_SPAN)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .depth       (depth),
    .cmd         (cmd),
    .status      (status),
    .edges_found (edges_found),
    .keep_start  (keep_start),
    .keep_end    (keep_end),
    .row_length  (row_length),
    .overflowed  (overflowed)
  );

endmodule

// ----- rtl/drtrim_checker.sv -----
// Port-level checks for the depth row edge trim block, bound to the top level.
// Depends on drtrim_pkg and depth_row_edge_trim_macros.svh.
`include "depth_row_edge_trim_macros.svh"

module drtrim_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         row_end,
  input logic                         done,
  input logic                         edges_found,
  input logic [drtrim_pkg::POS_W-1:0] keep_start,
  input logic [drtrim_pkg::POS_W-1:0] keep_end,
  input logic [drtrim_pkg::LEN_W-1:0] row_length
);
  import drtrim_pkg::*;

  // A result is only shown once the request that caused it has finished.
  `DRT_ASSERT_SAME(a_done_idle, done, !busy, "result strobed while busy")
  // A row end request always starts the evaluation.
  `DRT_ASSERT_NEXT(a_row_end_busy, start && !busy && row_end, busy, "row end not taken")
  // A kept-whole row reports the full span.
  `DRT_ASSERT_SAME(a_whole_row, done && !edges_found,
                   keep_start == '0 && keep_end == row_length[POS_W-1:0] - 10'd1,
                   "whole row span wrong")
  // Every row holds at least one pixel.
  `DRT_ASSERT_SAME(a_length_nonzero, done, row_length != '0, "empty row reported")

endmodule

bind depth_row_edge_trim drtrim_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .row_end     (row_end),
  .done        (done),
  .edges_found (edges_found),
  .keep_start  (keep_start),
  .keep_end    (keep_end),
  .row_length  (row_length)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for depth_row_edge_trim: drives depth rows pixel by pixel
// and checks each kept-span result against a predictor of the slope search and
// bound refinement. Depends on drtrim_pkg and the depth_row_edge_trim RTL.
module tb;
  import drtrim_pkg::*;

  localparam int ROW_MAX = 1024;
  localparam int SPAN = 2;
  localparam int SETTLE = 2 * 2047 + 6;

  typedef struct packed {
    logic             edges;
    logic [POS_W-1:0] first_kept;
    logic [POS_W-1:0] last_kept;
    logic [LEN_W-1:0] length;
    logic             ovf;
  } span_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               last;
    logic               typed;
    span_t              want;
  } pixel_t;

  localparam span_t NONE = '0;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [DEPTH_W-1:0]     depth = '0;
  logic                   row_end = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [REG_INDEX_W-1:0] cfg_index = REG_SLOPE_THRESHOLD;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   busy;
  logic                   done;
  logic                   edges_found;
  logic [POS_W-1:0]       keep_start;
  logic [POS_W-1:0]       keep_end;
  logic [LEN_W-1:0]       row_length;
  logic                   overflowed;

  depth_row_edge_trim #(
    .ROW_MAX(ROW_MAX),
    .SLOPE_SPAN(SPAN)
  ) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [DEPTH_W-1:0] row_mem [ROW_MAX];
  logic [THR_W-1:0]   thr_q;
  logic [CHECK_W-1:0] width_q;
  int                 pix_cnt;
  bit                 ovf_seen;
  int                 fail_cnt;
  int                 rand_items;
  int                 idle_pct;
  span_t              span_q[$];

  // A lone pixel, a two-pixel row at the depth extremes, a row whose refined
  // bounds cross, and a short row with one steep rise.
  pixel_t dir_tab [20] = '{
    '{16'h0000, 1'b1, 1'b1, '{1'b0, 10'd0, 10'd0, 11'd1, 1'b0}},
    '{16'hFFFF, 1'b0, 1'b0, NONE},
    '{16'h0000, 1'b1, 1'b1, '{1'b0, 10'd0, 10'd1, 11'd2, 1'b0}},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd500,  1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd900,  1'b1, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'd0,    1'b0, 1'b0, NONE},
    '{16'hFFFF, 1'b1, 1'b0, NONE}
  };

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want_v, got_v);
    end
  endtask

  // Sends one pixel request and, once it is taken, updates the predicted row.
  task automatic put_pixel(input logic [DEPTH_W-1:0] d, input logic last,
                           input logic typed, input span_t want);
    int n, x, diff, lim, lo, hi, s, e, rise_at, fall_at;
    bit rise_seen, fall_seen;
    logic [DEPTH_W-1:0] best;
    span_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    depth <= d;
    row_end <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (pix_cnt < ROW_MAX) begin
      row_mem[pix_cnt] = d;
      pix_cnt++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (last) begin
      n = pix_cnt;
      lim = SPAN * int'(thr_q);
      rise_seen = 1'b0;
      fall_seen = 1'b0;
      rise_at = 0;
      fall_at = 0;
      for (x = 0; x + 1 < n; x++) begin
        diff = 0;
        if (x >= SPAN && x + SPAN < n)
          diff = int'(row_mem[x + SPAN]) - int'(row_mem[x - SPAN]);
        if (diff >= lim) begin
          if (!rise_seen) begin
            rise_at = x;
            rise_seen = 1'b1;
          end
        end else if (diff <= -lim) begin
          fall_at = x;
          fall_seen = 1'b1;
        end
      end
      s = 0;
      e = n - 1;
      r.edges = rise_seen && fall_seen && rise_at < fall_at;
      if (r.edges) begin
        s = rise_at;
        best = row_mem[s];
        hi = s + int'(width_q);
        if (hi > n) hi = n;
        for (x = rise_at + 1; x < hi; x++) begin
          if (row_mem[x] > best) begin
            best = row_mem[x];
            s = x;
          end
        end
        e = fall_at;
        best = row_mem[e];
        lo = e - int'(width_q);
        if (lo < 0) lo = 0;
        for (x = fall_at - 1; x >= lo; x--) begin
          if (row_mem[x] > best) begin
            best = row_mem[x];
            e = x;
          end
        end
      end
      r.first_kept = s[POS_W-1:0];
      r.last_kept = e[POS_W-1:0];
      r.length = n[LEN_W-1:0];
      r.ovf = ovf_seen;
      span_q = {span_q, (typed ? want : r)};
      pix_cnt = 0;
      ovf_seen = 1'b0;
    end
  endtask

  // Shaped rows sit on a background and step up onto an object by at least twice
  // the threshold where the depth range allows; the others carry random depths over the full range.
  task automatic send_row(input int len, input bit shaped);
    int base, top, a, b, noise, v, i;
    base = $urandom_range(0, 3000);
    top = base + SPAN * int'(thr_q) + $urandom_range(0, 3000);
    if (top > 65535) top = 65535;
    a = $urandom_range(1, len / 2);
    b = $urandom_range(a + 1, len - 1);
    noise = $urandom_range(0, 60);
    for (i = 0; i < len; i++) begin
      if (!shaped)
        v = $urandom_range(0, 65535);
      else if ($urandom_range(99) < 4)
        v = 0;
      else
        v = ((i >= a && i <= b) ? top : base) + $urandom_range(0, noise);
      if (v > 65535) v = 65535;
      put_pixel(v[DEPTH_W-1:0], i == len - 1, 1'b0, NONE);
      rand_items++;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (span_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    span_t want;
    if (!rst && done) begin
      if (span_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("result with no row pending: span %0d..%0d", keep_start, keep_end);
      end else begin
        want = span_q.pop_front();
        check_field("edges_found", 32'(want.edges), 32'(edges_found));
        check_field("keep_start", 32'(want.first_kept), 32'(keep_start));
        check_field("keep_end", 32'(want.last_kept), 32'(keep_end));
        check_field("row_length", 32'(want.length), 32'(row_length));
        check_field("overflowed", 32'(want.ovf), 32'(overflowed));
      end
    end
  end

  initial begin : stimulus
    int ph, target;
    bit shaped;
    logic [CFG_DATA_W-1:0] thr_w, cw_w;
    thr_q = THRESHOLD_RESET;
    width_q = CHECK_WIDTH_RESET;
    pix_cnt = 0;
    ovf_seen = 1'b0;
    fail_cnt = 0;
    rand_items = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i])
      put_pixel(dir_tab[i].depth, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
    for (ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: begin
          thr_w = 16'd48;
          cw_w = 16'd10;
        end
        1: begin
          thr_w = 16'd0;
          cw_w = 16'd0;
        end
        2: begin
          thr_w = 16'hFFFF;
          cw_w = 16'd1024;
        end
        3: begin
          thr_w = 16'd1;
          cw_w = 16'd1;
        end
        4: begin
          thr_w = CFG_DATA_W'($urandom_range(1, 3000));
          cw_w = CFG_DATA_W'(32'hF800 | $urandom_range(0, 2047));
        end
        5: begin
          thr_w = CFG_DATA_W'($urandom_range(10, 400));
          cw_w = CFG_DATA_W'($urandom_range(1, 40));
        end
        default: begin
          thr_w = CFG_DATA_W'($urandom_range(1, 200));
          cw_w = 16'h07FF;
        end
      endcase
      cfg_we <= 1'b1;
      cfg_index <= REG_SLOPE_THRESHOLD;
      cfg_data <= thr_w;
      @(posedge clk);
      cfg_index <= REG_CHECK_WIDTH;
      cfg_data <= cw_w;
      @(posedge clk);
      cfg_we <= 1'b0;
      thr_q = thr_w;
      width_q = cw_w[CHECK_W-1:0];
      target = rand_items + 50;
      while (rand_items < target) begin
        idle_pct = (rand_items < 120) ? 19 : ((rand_items < 240) ? 88 : 0);
        shaped = $urandom_range(99) < 75;
        send_row(shaped ? $urandom_range(6, 60) : $urandom_range(1, 20), shaped);
      end
    end
    // A full-length row whose tail is dropped.
    idle_pct = 0;
    send_row(ROW_MAX + 4, 1'b1);
    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_cnt == 0 && span_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
